[hdl/tdcbd_pkg.sv]
package tdcbd_pkg;

    localparam int RAM_BYTES   = 2048;
    localparam int ROM_BYTES   = 1024;
    localparam int PAGE_BYTES  = 512;
    localparam int NUM_REGS    = 32;

    localparam int RAM_AW      = $clog2(RAM_BYTES);
    localparam int ROM_AW      = $clog2(ROM_BYTES);
    localparam int PAGE_AW     = $clog2(PAGE_BYTES);
    localparam int PAGE_SEL_W  = RAM_AW - PAGE_AW;

    localparam logic [ROM_AW-1:0] SLOT_ROM_BASE = ROM_AW'(12'h300);
    localparam logic [RAM_AW-1:0] WINDOW_LAST   = RAM_AW'(12'h7FF);
    localparam logic [7:0]        CHAR_H_MASK   = 8'h0F;
    localparam logic [7:0]        FLOAT_RESET   = 8'hFF;

    // CRTC register numbers used for the display parameters
    localparam int REG_CHARS_PER_ROW = 1;
    localparam int REG_ROWS_DISPLAY  = 6;
    localparam int REG_SCAN_LINES    = 9;
    localparam int REG_CURSOR_START  = 10;
    localparam int REG_CURSOR_END    = 11;
    localparam int REG_START_HI      = 12;
    localparam int REG_START_LO      = 13;
    localparam int REG_CURSOR_HI     = 14;
    localparam int REG_CURSOR_LO     = 15;

    typedef struct packed {
        logic       wr_index;
        logic       wr_reg;
        logic [7:0] data;
    } t_crtc_req;

    typedef struct packed {
        logic [7:0]        chars_per_row;
        logic [7:0]        rows_displayed;
        logic [4:0]        scan_lines;
        logic [7:0]        cursor_start;
        logic [7:0]        cursor_end;
        logic [RAM_AW-1:0] display_start;
        logic [RAM_AW-1:0] cursor_position;
    } t_disp;

endpackage

[hdl/tdcbd_ram.sv]
module tdcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tdcbd_crtc.sv]
module tdcbd_crtc #(
    parameter int NUM_REGS = tdcbd_pkg::NUM_REGS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdcbd_pkg::t_crtc_req i_req,
    output logic [7:0]           o_rd_byte,
    output tdcbd_pkg::t_disp     o_disp
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [7:0]       r_regs [NUM_REGS];
    logic [IDX_W-1:0] r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_req.wr_index) begin
                r_index <= IDX_W'(i_req.data);
            end
            if (i_req.wr_reg) begin
                r_regs[r_index] <= i_req.data;
            end
        end
    end

    assign o_rd_byte = r_regs[r_index];

    always_comb begin
        o_disp.chars_per_row  = r_regs[IDX_W'(tdcbd_pkg::REG_CHARS_PER_ROW)];
        o_disp.rows_displayed = r_regs[IDX_W'(tdcbd_pkg::REG_ROWS_DISPLAY)];
        o_disp.scan_lines     = 5'((r_regs[IDX_W'(tdcbd_pkg::REG_SCAN_LINES)]
                                    & tdcbd_pkg::CHAR_H_MASK) + 8'd1);
        o_disp.cursor_start   = r_regs[IDX_W'(tdcbd_pkg::REG_CURSOR_START)];
        o_disp.cursor_end     = r_regs[IDX_W'(tdcbd_pkg::REG_CURSOR_END)];
        // keep only the bits that address the video RAM
        o_disp.display_start  = tdcbd_pkg::RAM_AW'({
                                    r_regs[IDX_W'(tdcbd_pkg::REG_START_HI)],
                                    r_regs[IDX_W'(tdcbd_pkg::REG_START_LO)]});
        o_disp.cursor_position = tdcbd_pkg::RAM_AW'({
                                    r_regs[IDX_W'(tdcbd_pkg::REG_CURSOR_HI)],
                                    r_regs[IDX_W'(tdcbd_pkg::REG_CURSOR_LO)]});
    end

endmodule

[hdl/text_display_card_bus_decode.sv]
// Latency: a result is shown in the cycle after its bus access beat is accepted.
// Throughput: one access per cycle while the result side accepts; ROM and
// video RAM each take one single-port access per beat, and the output register
// holds while the result side stalls. Reset: CRTC registers, index, RAM page and
// window clear at once; then a pass writes zero to all 2048 video RAM bytes with
// input ready low. The ROM image is undefined until loaded.
module text_display_card_bus_decode #(
    parameter int NUM_REGS = tdcbd_pkg::NUM_REGS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_opcode,
    input  logic [tdcbd_pkg::RAM_AW-1:0]  i_address,
    input  logic [7:0]                    i_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_read_data,
    output logic                          o_window_enabled,
    output logic [7:0]                    o_chars_per_row,
    output logic [7:0]                    o_rows_displayed,
    output logic [4:0]                    o_scan_lines,
    output logic [7:0]                    o_cursor_start,
    output logic [7:0]                    o_cursor_end,
    output logic [tdcbd_pkg::RAM_AW-1:0]  o_display_start,
    output logic [tdcbd_pkg::RAM_AW-1:0]  o_cursor_position
);

    localparam int RAM_AW  = tdcbd_pkg::RAM_AW;
    localparam int ROM_AW  = tdcbd_pkg::ROM_AW;
    localparam int PAGE_AW = tdcbd_pkg::PAGE_AW;
    localparam int PSEL_W  = tdcbd_pkg::PAGE_SEL_W;

    typedef enum logic [2:0] {
        OP_IO_RD    = 3'd0,
        OP_IO_WR    = 3'd1,
        OP_SLOT_RD  = 3'd2,
        OP_SLOT_WR  = 3'd3,
        OP_WIN_RD   = 3'd4,
        OP_WIN_WR   = 3'd5,
        OP_ROM_LOAD = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        SRC_FLOAT,
        SRC_REG,
        SRC_ROM,
        SRC_RAM
    } t_src;

    logic [7:0]        r_float;
    logic              r_window_on;
    logic [PSEL_W-1:0] r_page;
    logic              r_out_valid;
    t_src              r_src;
    logic [7:0]        r_rd_byte;
    logic              r_clearing;
    logic [RAM_AW-1:0] r_clr_addr;

    logic              n_window_on;
    logic [PSEL_W-1:0] n_page;
    t_src              n_src;

    logic              acc;
    t_opcode           op;
    logic              rom_hit;
    logic              ram_hit;
    logic [RAM_AW-1:0] win_off;

    logic              rom_en;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic [7:0]        rom_q;
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_q;

    tdcbd_pkg::t_crtc_req crtc_req;
    tdcbd_pkg::t_disp     disp;
    logic [7:0]           crtc_byte;

    assign o_in_ready = !r_clearing && (!r_out_valid || i_out_ready);
    assign acc        = i_in_valid && o_in_ready;
    assign op         = t_opcode'(i_opcode);

    assign win_off = i_address - RAM_AW'(tdcbd_pkg::ROM_BYTES);
    assign rom_hit = r_window_on && (i_address < RAM_AW'(tdcbd_pkg::ROM_BYTES));
    assign ram_hit = r_window_on && !rom_hit
                     && (win_off < RAM_AW'(tdcbd_pkg::PAGE_BYTES));

    always_comb begin
        n_window_on = r_window_on;
        n_page      = r_page;
        n_src       = SRC_FLOAT;
        rom_en      = 1'b0;
        rom_we      = 1'b0;
        rom_addr    = i_address[ROM_AW-1:0];
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        crtc_req    = '{wr_index: 1'b0, wr_reg: 1'b0, data: i_data};
        unique case (op)
            OP_IO_RD: begin
                n_page = i_address[3:2];
                n_src  = SRC_REG;
            end
            OP_IO_WR: begin
                n_page          = i_address[3:2];
                crtc_req.wr_reg   = acc && i_address[0];
                crtc_req.wr_index = acc && !i_address[0];
            end
            OP_SLOT_RD: begin
                n_window_on = 1'b1;
                n_src       = SRC_ROM;
                rom_en      = acc;
                rom_addr    = ROM_AW'({2'b00, i_address[7:0]} + tdcbd_pkg::SLOT_ROM_BASE);
            end
            OP_SLOT_WR: begin
                n_window_on = 1'b1;
            end
            OP_WIN_RD, OP_WIN_WR: begin
                if (op == OP_WIN_RD && rom_hit) begin
                    n_src  = SRC_ROM;
                    rom_en = acc;
                end
                if (ram_hit) begin
                    ram_en = acc;
                    ram_we = (op == OP_WIN_WR);
                    if (op == OP_WIN_RD) begin
                        n_src = SRC_RAM;
                    end
                end
                // the last window offset closes the window once served
                if (r_window_on && i_address == tdcbd_pkg::WINDOW_LAST) begin
                    n_window_on = 1'b0;
                end
            end
            OP_ROM_LOAD: begin
                rom_en = acc;
                rom_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // the clearing pass owns the video RAM port until it finishes
    assign ram_addr  = r_clearing ? r_clr_addr : {r_page, win_off[PAGE_AW-1:0]};
    assign ram_wdata = r_clearing ? 8'd0 : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_float     <= tdcbd_pkg::FLOAT_RESET;
            r_window_on <= 1'b0;
            r_page      <= '0;
            r_out_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_float <= i_cfg_data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + RAM_AW'(1);
                if (r_clr_addr == RAM_AW'(tdcbd_pkg::RAM_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (acc) begin
                r_window_on <= n_window_on;
                r_page      <= n_page;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: hold while the output beat waits
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_src     <= n_src;
            r_rd_byte <= crtc_byte;
        end
    end

    tdcbd_ram #(
        .WIDTH (8),
        .DEPTH (tdcbd_pkg::ROM_BYTES)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (rom_en),
        .i_we    (rom_we),
        .i_addr  (rom_addr),
        .i_wdata (i_data),
        .o_rdata (rom_q)
    );

    tdcbd_ram #(
        .WIDTH (8),
        .DEPTH (tdcbd_pkg::RAM_BYTES)
    ) u_vram (
        .i_clk   (i_clk),
        .i_en    (ram_en || r_clearing),
        .i_we    (ram_we || r_clearing),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    tdcbd_crtc #(
        .NUM_REGS (NUM_REGS)
    ) u_crtc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (crtc_req),
        .o_rd_byte (crtc_byte),
        .o_disp    (disp)
    );

    always_comb begin
        unique case (r_src)
            SRC_REG:   o_read_data = r_rd_byte;
            SRC_ROM:   o_read_data = rom_q;
            SRC_RAM:   o_read_data = ram_q;
            default:   o_read_data = r_float;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_window_enabled  = r_window_on;
    assign o_chars_per_row   = disp.chars_per_row;
    assign o_rows_displayed  = disp.rows_displayed;
    assign o_scan_lines      = disp.scan_lines;
    assign o_cursor_start    = disp.cursor_start;
    assign o_cursor_end      = disp.cursor_end;
    assign o_display_start   = disp.display_start;
    assign o_cursor_position = disp.cursor_position;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_in_ready)
        else $error("input ready during video RAM clearing pass");

    a_clear_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> r_clr_addr == '0)
        else $error("clearing pass ended before covering the video RAM");

    a_slot_opens_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (op == OP_SLOT_RD || op == OP_SLOT_WR) |=> o_window_enabled)
        else $error("slot ROM access did not open the window");

    a_last_closes_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (op == OP_WIN_RD || op == OP_WIN_WR)
            && i_address == tdcbd_pkg::WINDOW_LAST |=> !o_window_enabled)
        else $error("last window offset left the window open");

endmodule
